// ===== sv/pfcp_pkg.sv =====
package pfcp_pkg;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_PREFIX = 2'd1,
        MODE_CAND   = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    localparam logic [7:0]  DOT_CHAR     = 8'h2E;
    localparam logic [15:0] MATCH_MAX    = 16'hFFFF;
    localparam logic        REG_LOGNAMES = 1'b0;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] char_in;
        logic       name_end;
        logic [7:0] read_index;
    } item_t;

endpackage

// ===== sv/pfcp_ram.sv =====
module pfcp_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pfcp_core.sv =====
module pfcp_core #(
    parameter int NAME_LEN = 256,
    parameter int AW       = 8,
    parameter int LW       = 9
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  pfcp_pkg::item_t item,
    input  logic [LW-1:0]  pos,
    input  logic [LW-1:0]  plen,
    input  logic [7:0]     pre_data,
    input  logic [7:0]     ext_data,
    input  logic           lognames,
    output logic           ext_we,
    output logic [AW-1:0]  ext_waddr,
    output logic [7:0]     ext_wdata,
    output logic [15:0]    match_count,
    output logic [8:0]     ext_length,
    output logic           stopped,
    output logic           entry_matched,
    output logic [7:0]     read_char
);

    import pfcp_pkg::*;

    localparam int CW = LW + 8;
    localparam int EW = LW + 9;

    logic [LW-1:0] ext_len_reg, ext_len_next;
    logic [15:0]   matches_reg, matches_next;
    logic [LW-1:0] common_reg, common_next;
    logic          pok_reg, pok_next;
    logic          div_reg, div_next;
    logic          dot_reg, dot_next;
    logic          done_reg, done_next;

    logic [LW-1:0] pos_after;
    logic          hit;
    logic [7:0]    rd;
    logic          we;
    logic [EW-1:0] ext_len_wide;

    logic [15:0]   match_count_reg;
    logic [8:0]    ext_length_reg;
    logic          stopped_reg;
    logic          entry_matched_reg;
    logic [7:0]    read_char_reg;

    always_comb
    begin
        ext_len_next = ext_len_reg;
        matches_next = matches_reg;
        common_next  = common_reg;
        pok_next     = pok_reg;
        div_next     = div_reg;
        dot_next     = dot_reg;
        done_next    = done_reg;
        pos_after    = pos;
        hit          = 1'b0;
        rd           = 8'd0;
        we           = 1'b0;
        case (item.mode)
            MODE_START:
            begin
                ext_len_next = '0;
                matches_next = '0;
                done_next    = 1'b0;
                common_next  = '0;
                pok_next     = 1'b1;
                div_next     = 1'b0;
                dot_next     = 1'b0;
            end
            MODE_CAND:
            begin
                if (!done_reg)
                begin
                    if (pos < NAME_LEN)
                    begin
                        pos_after = pos + LW'(1);
                        if (pos == '0)
                        begin
                            dot_next = (item.char_in == DOT_CHAR);
                        end
                        if (pos < plen && item.char_in != pre_data)
                        begin
                            pok_next = 1'b0;
                        end
                        if (matches_reg == '0)
                        begin
                            we = 1'b1;
                        end
                        else if (!div_reg)
                        begin
                            if (pos < ext_len_reg && item.char_in == ext_data)
                            begin
                                common_next = common_reg + LW'(1);
                            end
                            else
                            begin
                                div_next = 1'b1;
                            end
                        end
                    end
                    if (item.name_end)
                    begin
                        if (pok_next && pos_after >= plen &&
                            !(plen == '0 && dot_next && !lognames))
                        begin
                            hit = 1'b1;
                            if (matches_reg == '0)
                            begin
                                ext_len_next = pos_after;
                            end
                            else
                            begin
                                if (common_next < ext_len_reg)
                                begin
                                    ext_len_next = common_next;
                                end
                                if (common_next == plen)
                                begin
                                    done_next = 1'b1;
                                end
                            end
                            if (matches_reg != MATCH_MAX)
                            begin
                                matches_next = matches_reg + 16'd1;
                            end
                        end
                        common_next = '0;
                        pok_next    = 1'b1;
                        div_next    = 1'b0;
                        dot_next    = 1'b0;
                    end
                end
            end
            MODE_READ:
            begin
                if (CW'(item.read_index) < CW'(ext_len_reg) && item.read_index < NAME_LEN)
                begin
                    rd = ext_data;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ext_len_wide = EW'(ext_len_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_len_reg <= '0;
            matches_reg <= '0;
            common_reg  <= '0;
            pok_reg     <= 1'b1;
            div_reg     <= 1'b0;
            dot_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (adv)
        begin
            ext_len_reg <= ext_len_next;
            matches_reg <= matches_next;
            common_reg  <= common_next;
            pok_reg     <= pok_next;
            div_reg     <= div_next;
            dot_reg     <= dot_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            match_count_reg   <= matches_next;
            ext_length_reg    <= ext_len_wide[8:0];
            stopped_reg       <= done_next;
            entry_matched_reg <= hit;
            read_char_reg     <= rd;
        end
    end

    assign ext_we        = adv && we;
    assign ext_waddr     = pos[AW-1:0];
    assign ext_wdata     = item.char_in;
    assign match_count   = match_count_reg;
    assign ext_length    = ext_length_reg;
    assign stopped       = stopped_reg;
    assign entry_matched = entry_matched_reg;
    assign read_char     = read_char_reg;

endmodule

// ===== sv/prefix_filter_common_prefix.sv =====
// Common-prefix completion filter. Takes one request per clock (mode start, prefix
// character, candidate character or extended-name read) and returns exactly one result
// per request, so the sustained rate is one request per cycle while out_stall is low,
// each passing the stage 1 and output registers to out_valid. The prefix and the
// extended name each live in a NAME_LEN x 8 synchronous RAM, read when a request is
// accepted; stage 1 updates the candidate state and writes the extended name back,
// with the write of the request ahead forwarded to the read behind it. Both stores are
// left undefined after reset and only ever read where they have been written, so there
// is no clearing pass. lognames_mode (byte address 0) turns off dot-name skipping.
module prefix_filter_common_prefix #(
    parameter int NAME_LEN = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_in,
    input  logic        name_end,
    input  logic [7:0]  read_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] match_count,
    output logic [8:0]  ext_length,
    output logic        stopped,
    output logic        entry_matched,
    output logic [7:0]  read_char
);

    import pfcp_pkg::*;

    localparam int AW = $clog2(NAME_LEN);
    localparam int LW = $clog2(NAME_LEN + 1);

    logic          lognames_reg;
    logic          cfg_we;

    logic          accept;
    logic          s1_adv;
    logic          s1_valid_reg, s1_valid_next;
    item_t         s1_item_reg;
    logic [LW-1:0] s1_pos_reg;
    logic [LW-1:0] s1_plen_reg;
    logic          out_valid_reg, out_valid_next;

    logic [LW-1:0] cand_pos_reg, cand_pos_next;
    logic [LW-1:0] prefix_len_reg, prefix_len_next;
    logic          prefix_we;
    item_t         in_item;

    logic [AW-1:0] ext_raddr;
    logic [7:0]    pre_rdata;
    logic [7:0]    ext_rdata;
    logic [7:0]    ext_data;
    logic          ext_we;
    logic [AW-1:0] ext_waddr;
    logic [7:0]    ext_wdata;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;

    // config port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_LOGNAMES);
    assign prdata = (paddr[2] == REG_LOGNAMES) ? {31'd0, lognames_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lognames_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            lognames_reg <= pwdata[0];
        end
    end

    // handshake
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign accept   = in_valid && !in_stall;

    assign in_item.mode       = mode_t'(mode);
    assign in_item.char_in    = char_in;
    assign in_item.name_end   = name_end;
    assign in_item.read_index = read_index;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // front: positions needed to address the stores
    always_comb
    begin
        cand_pos_next   = cand_pos_reg;
        prefix_len_next = prefix_len_reg;
        prefix_we       = 1'b0;
        case (in_item.mode)
            MODE_START:
            begin
                cand_pos_next   = '0;
                prefix_len_next = '0;
            end
            MODE_PREFIX:
            begin
                if (prefix_len_reg < NAME_LEN)
                begin
                    prefix_we       = 1'b1;
                    prefix_len_next = prefix_len_reg + LW'(1);
                end
            end
            MODE_CAND:
            begin
                if (name_end)
                begin
                    cand_pos_next = '0;
                end
                else if (cand_pos_reg < NAME_LEN)
                begin
                    cand_pos_next = cand_pos_reg + LW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign ext_raddr = (in_item.mode == MODE_READ) ? AW'(read_index) : cand_pos_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cand_pos_reg   <= '0;
            prefix_len_reg <= '0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                cand_pos_reg   <= cand_pos_next;
                prefix_len_reg <= prefix_len_next;
                fwd_hit_reg    <= ext_we && (ext_waddr == ext_raddr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= in_item;
            s1_pos_reg   <= cand_pos_reg;
            s1_plen_reg  <= prefix_len_reg;
            fwd_data_reg <= ext_wdata;
        end
    end

    assign ext_data = fwd_hit_reg ? fwd_data_reg : ext_rdata;

    pfcp_ram #(
        .DEPTH (NAME_LEN),
        .AW    (AW)
    ) u_prefix_ram (
        .clk   (clk),
        .we    (accept && prefix_we),
        .waddr (prefix_len_reg[AW-1:0]),
        .wdata (char_in),
        .re    (accept),
        .raddr (cand_pos_reg[AW-1:0]),
        .rdata (pre_rdata)
    );

    pfcp_ram #(
        .DEPTH (NAME_LEN),
        .AW    (AW)
    ) u_ext_ram (
        .clk   (clk),
        .we    (ext_we),
        .waddr (ext_waddr),
        .wdata (ext_wdata),
        .re    (accept),
        .raddr (ext_raddr),
        .rdata (ext_rdata)
    );

    pfcp_core #(
        .NAME_LEN (NAME_LEN),
        .AW       (AW),
        .LW       (LW)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (s1_adv),
        .item          (s1_item_reg),
        .pos           (s1_pos_reg),
        .plen          (s1_plen_reg),
        .pre_data      (pre_rdata),
        .ext_data      (ext_data),
        .lognames      (lognames_reg),
        .ext_we        (ext_we),
        .ext_waddr     (ext_waddr),
        .ext_wdata     (ext_wdata),
        .match_count   (match_count),
        .ext_length    (ext_length),
        .stopped       (stopped),
        .entry_matched (entry_matched),
        .read_char     (read_char)
    );

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_stall_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with stage 1 empty");

    a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("request advanced without a result");

    a_stop_has_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stopped) |-> (match_count != 16'd0))
        else $error("stopped with no matches");

    a_ext_write_only_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
        ext_we |-> (s1_adv && s1_item_reg.mode == MODE_CAND))
        else $error("extended name written outside a candidate update");
`endif

endmodule
